### design/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int unsigned COLUMNS_DEFAULT = 80;
  localparam int unsigned ROWS_DEFAULT    = 25;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [7:0]  RESET_COLOR  = 8'h07;
  localparam logic [15:0] RESET_CELL   = {RESET_COLOR, SPACE_CODE};

  // Word index of the text color register (paddr bit 2).
  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_FILL,
    S_FINISH
  } state_e;

endpackage

### design/text_console_writer.sv
`timescale 1ns / 1ps

// Text console writer: a character console of ROWS x COLUMNS 16-bit cells (character in
// the low byte, attribute in the high byte) held in one single-port-write, registered-read
// memory. One item is taken at a time. A put, a read or an unused action goes through the
// execute and finish states; the finish state waits until the output is free, then registers
// the result and makes the input ready again. A put that pushes the cursor past the last
// row scrolls the screen: rows are copied up one place and the last row is filled with
// spaces, so every cell is written once. A clear walks the whole memory too, filling it
// with spaces in the text color. After reset the block blanks the memory to 0x0720
// with s_axis_tready_o low; register writes are taken during that pass. A finished result
// may wait on the output while the next item is taken.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = ROWS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] char_code, [18:8] cell_index
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  // stream out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] cell_value, [20:16] cursor_row,
                                        // [27:21] cursor_col, [28] scrolled
  // configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);

  localparam logic [AW:0]   CELLS_W     = (AW + 1)'(CELLS);
  localparam logic [AW:0]   LAST_CELL   = (AW + 1)'(CELLS - 1);
  localparam logic [AW:0]   COLUMNS_W   = (AW + 1)'(COLUMNS);
  localparam logic [AW-1:0] ROW_STEP    = AW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COLUMN = CW'(COLUMNS - 1);

  state_e         state_q, state_d;
  action_e        act_q, act_d;
  logic [7:0]     char_q, char_d;
  logic [10:0]    idx_q, idx_d;
  logic [RW-1:0]  row_q, row_d;
  logic [CW-1:0]  col_q, col_d;
  logic [AW-1:0]  row_base_q, row_base_d;
  logic [AW-1:0]  cur_q, cur_d;
  logic [AW:0]    src_q, src_d;
  logic [AW:0]    dst_q, dst_d;
  logic           pend_q, pend_d;
  logic           scr_q, scr_d;
  logic [7:0]     color_q;
  logic           out_valid_q, out_valid_d;
  logic [31:0]    out_data_q, out_data_d;

  logic [15:0]    mem [CELLS];
  logic [15:0]    rdata_q;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [15:0]    mem_wdata;

  logic           s_xfer, out_free, row_last, col_last, src_live, idx_valid, cfg_we;
  logic [31:0]    row_ext, col_ext;
  logic [15:0]    value;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign row_last        = (row_q == LAST_ROW);
  assign col_last        = (col_q == LAST_COLUMN);
  assign src_live        = (src_q < CELLS_W);
  assign idx_valid       = (32'(idx_q) < CELLS);
  assign row_ext         = 32'(row_q);
  assign col_ext         = 32'(col_q);
  assign value           = (act_q == ACT_READ && idx_valid) ? rdata_q : 16'd0;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o
                    && (paddr_i[2] == REG_TEXT_COLOR);
  assign prdata_o = (paddr_i[2] == REG_TEXT_COLOR) ? 32'(color_q) : 32'd0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (dst_q == LAST_CELL) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_xfer) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (act_q)
          ACT_PUT: begin
            if (row_last && (char_q == NEWLINE_CODE || col_last)) begin
              state_d = S_SCROLL;
            end else begin
              state_d = S_FINISH;
            end
          end
          ACT_CLEAR: state_d = S_FILL;
          default:   state_d = S_FINISH;
        endcase
      end
      S_SCROLL: begin
        if (!src_live && !pend_q) state_d = S_FILL;
      end
      S_FILL: begin
        if (dst_q == LAST_CELL) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    act_d       = act_q;
    char_d      = char_q;
    idx_d       = idx_q;
    row_d       = row_q;
    col_d       = col_q;
    row_base_d  = row_base_q;
    cur_d       = cur_q;
    src_d       = src_q;
    dst_d       = dst_q;
    pend_d      = 1'b0;
    scr_d       = scr_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    mem_wdata   = '0;
    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = dst_q[AW-1:0];
        mem_wdata = RESET_CELL;
        dst_d     = dst_q + 1'b1;
      end
      S_IDLE: begin
        if (s_xfer) begin
          act_d  = action_e'(s_axis_tuser_i);
          char_d = s_axis_tdata_i[7:0];
          idx_d  = s_axis_tdata_i[18:8];
          scr_d  = 1'b0;
        end
      end
      S_EXEC: begin
        case (act_q)
          ACT_PUT: begin
            if (char_q != NEWLINE_CODE) begin
              mem_we    = 1'b1;
              mem_waddr = cur_q;
              mem_wdata = {color_q, char_q};
            end
            if (char_q == NEWLINE_CODE || col_last) begin
              col_d = '0;
              if (row_last) begin
                // stay on the last row and move the screen up
                scr_d = 1'b1;
                src_d = COLUMNS_W;
                dst_d = '0;
                cur_d = row_base_q;
              end else begin
                row_d      = row_q + 1'b1;
                row_base_d = row_base_q + ROW_STEP;
                cur_d      = row_base_q + ROW_STEP;
              end
            end else begin
              col_d = col_q + 1'b1;
              cur_d = cur_q + 1'b1;
            end
          end
          ACT_READ: begin
            mem_re    = idx_valid;
            mem_raddr = AW'(idx_q);
          end
          ACT_CLEAR: begin
            dst_d      = '0;
            row_d      = '0;
            col_d      = '0;
            row_base_d = '0;
            cur_d      = '0;
          end
          default: ;
        endcase
      end
      S_SCROLL: begin
        // read one row ahead, write back the cell read in the previous cycle
        mem_re    = src_live;
        mem_raddr = src_q[AW-1:0];
        pend_d    = src_live;
        if (src_live) src_d = src_q + 1'b1;
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = dst_q[AW-1:0];
          mem_wdata = rdata_q;
          dst_d     = dst_q + 1'b1;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = dst_q[AW-1:0];
        mem_wdata = {color_q, SPACE_CODE};
        dst_d     = dst_q + 1'b1;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, scr_q, col_ext[6:0], row_ext[4:0], value};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      row_q       <= '0;
      col_q       <= '0;
      row_base_q  <= '0;
      cur_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      pend_q      <= 1'b0;
      scr_q       <= 1'b0;
      color_q     <= RESET_COLOR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      row_base_q  <= row_base_d;
      cur_q       <= cur_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      pend_q      <= pend_d;
      scr_q       <= scr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) color_q <= pwdata_i[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    char_q     <= char_d;
    idx_q      <= idx_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

endmodule

### design/tcw_checker.sv
`timescale 1ns / 1ps

module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // a result waiting on the output holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // one item at a time: no transfer in the cycle after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  // a scroll leaves the cursor at the start of the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[28] |->
      m_axis_tdata_o[27:21] == 7'd0 && 32'(m_axis_tdata_o[20:16]) == (ROWS - 1) % 32)
    else $error("scroll did not leave cursor on last row");

  // the reported cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (32'(m_axis_tdata_o[20:16]) < ROWS || ROWS > 32)
      && (32'(m_axis_tdata_o[27:21]) < COLUMNS || COLUMNS > 128))
    else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
